// ----- sv/nearest_neighbor_value_search_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Nearest neighbour value search - assertion macros
// Concurrent assertion wrappers shared by the RTL files. They are empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_VALUE_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOR_VALUE_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset
`define NNVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included
`define NNVS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define NNVS_ASSERT(lbl, prop, msg)
`define NNVS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/nnvs_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest neighbour value search - package
// Sizes, opcodes, status codes, payload types and the controller interface.
// ----------------------------------------------------------------------------
package nnvs_pkg;

  // Store geometry
  localparam int DEPTH  = 512;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int VAL_W  = 32;
  localparam int POS_W  = 9;
  localparam int CNTO_W = 10;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PRED   = 2'd2,
    OP_SUCC   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_e;

  typedef struct packed {
    op_e                     opcode;
    logic signed [VAL_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    stat_e                   status;
    logic [POS_W-1:0]        target_position;
    logic signed [VAL_W-1:0] target_value;
    logic                    used_fallback;
    logic [CNTO_W-1:0]       stored_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE,
    ST_HOLD
  } state_e;

  typedef enum logic [1:0] {
    RES_IMM,
    RES_PEND,
    RES_SRCH
  } res_sel_e;

  typedef struct packed {
    logic     accept;
    logic     scan_start;
    logic     scan_step;
    logic     pend_load;
    logic     out_load;
    res_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
  } sts_t;

endpackage

// ----- sv/nearest_neighbor_value_search_unit.sv -----
// ----------------------------------------------------------------------------
// Nearest neighbour value search unit - top level
// Ordered store of signed values with clear, append, predecessor and
// successor search (extreme value taken when nothing qualifies).
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-----------------------
//   input   | in_valid_i | in_stall_o  | in_data_i  (in_item_t)
//   output  | out_valid_o| out_stall_i | out_data_o (out_item_t)
//
// Clear, append and search of an empty store are answered without a scan.
// Search: the scan reads one stored entry per cycle through the single read
// port of the value store, then passes through ST_FLUSH and ST_DONE.
// Reset empties the store through the entry count; no clearing pass.
// A result waits in the output register under stall; the next item is
// still taken and its result is parked until the register is free.
// ----------------------------------------------------------------------------
module nearest_neighbor_value_search_unit
  import nnvs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // controller
  nnvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  nnvs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ----- sv/nnvs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module nnvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/nnvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Nearest neighbour value search - controller
// Sequences accept, scan and result transfer; owns the output valid flag.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_value_search_unit_defines.svh"

module nnvs_ctrl
  import nnvs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  in_op_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;
  logic   is_search;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign is_search   = (in_op_i == OP_PRED) || (in_op_i == OP_SUCC);

  // state and valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_sel = RES_IMM;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (is_search && !sts_i.cnt_zero) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end else if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = RES_IMM;
          end else begin
            // result register still occupied: park the result
            cmd_o.pend_load = 1'b1;
            state_d         = ST_HOLD;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last read word is compared this cycle
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_SRCH;
          state_d        = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_PEND;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // checks
  `NNVS_ASSERT(a_no_overwrite, cmd_o.out_load |-> out_free, "unread result overwritten")
  `NNVS_ASSERT(a_busy_stalls, (state_q != ST_IDLE) |-> in_stall_o, "input taken while busy")
  `NNVS_ASSERT(a_scan_nonempty, (state_q == ST_SCAN) |-> !sts_i.cnt_zero, "scan of empty store")

endmodule

// ----- sv/nnvs_dp.sv -----
// ----------------------------------------------------------------------------
// Nearest neighbour value search - datapath
// Value store, entry count, scan index, candidate tracking and result register.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_value_search_unit_defines.svh"

module nnvs_dp
  import nnvs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_item_t out_data_o
);

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [ADDR_W-1:0]       idx_q;
  logic                    full;
  logic                    wr_en;
  op_e                     op_q;
  logic signed [VAL_W-1:0] qry_q;
  logic                    rd_vld_q;
  logic [ADDR_W-1:0]       rd_pos_q;
  logic signed [VAL_W-1:0] rd_data;
  logic                    found_q;
  logic [ADDR_W-1:0]       best_pos_q, ext_pos_q;
  logic signed [VAL_W-1:0] best_val_q, ext_val_q;
  logic                    qual, better, ext_better, first;
  out_item_t               imm, srch, pend_q, out_q;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign wr_en = cmd_i.accept && (in_data_i.opcode == OP_APPEND) && !full;

  // value store
  nnvs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (in_data_i.operand_value),
    .re_i    (cmd_i.scan_step),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // entry count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.accept && (in_data_i.opcode == OP_CLEAR)) begin
      cnt_d = '0;
    end else if (wr_en) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // result of items answered without a scan: clear, append, search of an empty store
  always_comb begin
    imm              = '0;
    imm.status       = STAT_OK;
    imm.stored_count = CNTO_W'(cnt_d);
    unique case (in_data_i.opcode)
      OP_CLEAR:  imm.status = STAT_OK;
      OP_APPEND: imm.status = full ? STAT_FULL : STAT_OK;
      default:   imm.status = STAT_EMPTY;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
      end else if (rd_vld_q && qual && better) begin
        found_q <= 1'b1;
      end
    end
  end

  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.scan_last = (CNT_W'(idx_q) == (cnt_q - 1'b1));

  // candidate tests on the word just read
  assign first = (rd_pos_q == '0);
  always_comb begin
    if (op_q == OP_PRED) begin
      qual       = rd_data < qry_q;
      better     = !found_q || (rd_data > best_val_q);
      ext_better = first || (rd_data > ext_val_q);
    end else begin
      qual       = rd_data > qry_q;
      better     = !found_q || (rd_data < best_val_q);
      ext_better = first || (rd_data < ext_val_q);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_data_i.opcode;
      qry_q <= in_data_i.operand_value;
    end
    rd_pos_q <= idx_q;
    if (rd_vld_q && qual && better) begin
      best_pos_q <= rd_pos_q;
      best_val_q <= rd_data;
    end
    if (rd_vld_q && ext_better) begin
      ext_pos_q <= rd_pos_q;
      ext_val_q <= rd_data;
    end
    if (cmd_i.pend_load) begin
      pend_q <= imm;
    end
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_sel)
        RES_IMM:  out_q <= imm;
        RES_PEND: out_q <= pend_q;
        RES_SRCH: out_q <= srch;
        default:  out_q <= imm;
      endcase
    end
  end

  // search result: nearest qualifying value, else the extreme
  always_comb begin
    srch                 = '0;
    srch.status          = STAT_OK;
    srch.target_position = POS_W'(found_q ? best_pos_q : ext_pos_q);
    srch.target_value    = found_q ? best_val_q : ext_val_q;
    srch.used_fallback   = !found_q;
    srch.stored_count    = CNTO_W'(cnt_q);
  end

  assign out_data_o = out_q;

  // checks
  `NNVS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
  `NNVS_ASSERT(a_rd_in_range, rd_vld_q |-> (CNT_W'(rd_pos_q) < cnt_q), "read beyond filled entries")

endmodule
